>>> sv/edrx_pkg.sv
`default_nettype none

package edrx_pkg;

  // receive-side operation codes
  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_FLUSH   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HEADER        = 2'd0;
  localparam logic [1:0] REG_ESCAPE        = 2'd1;
  localparam logic [1:0] REG_ESCAPE_OFFSET = 2'd2;
  localparam logic [1:0] REG_CANCEL_OPCODE = 2'd3;

  localparam logic [7:0] HEADER_RESET        = 8'hFE;
  localparam logic [7:0] ESCAPE_RESET        = 8'hFD;
  localparam logic [7:0] ESCAPE_OFFSET_RESET = 8'h01;
  localparam logic [7:0] CANCEL_OPCODE_RESET = 8'h00;

  // abort sequence: FE 03 <cancel opcode> 99 50
  localparam logic [7:0] ABORT_BYTE0 = 8'hFE;
  localparam logic [7:0] ABORT_BYTE1 = 8'h03;
  localparam logic [7:0] ABORT_BYTE3 = 8'h99;
  localparam logic [7:0] ABORT_BYTE4 = 8'h50;
  localparam logic [2:0] ABORT_LEN   = 3'd5;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 256;
  localparam int unsigned QUEUE_DEPTH        = 4;
  localparam int unsigned FILL_W             = 9;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_READ,
    CMD_FLUSH,
    CMD_ABORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              read_valid;
    logic              byte_stored;
    logic              overflow_drop;
    logic              cancel_seen;
    logic [FILL_W-1:0] fill_count;
  } res_t;

  function automatic logic [7:0] abort_byte(input logic [2:0] pos, input logic [7:0] opcode);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = ABORT_BYTE0;
      3'd1:    b = ABORT_BYTE1;
      3'd2:    b = opcode;
      3'd3:    b = ABORT_BYTE3;
      default: b = ABORT_BYTE4;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> sv/escape_decode_rx_fifo_with_abort.sv
`default_nettype none

// channel   | transfer when           | payload
// ----------+-------------------------+-----------------------------------------
// input     | push & !full            | operation, rx_byte, long_transfer
// result    | pop & !empty            | read_byte, read_valid, byte_stored,
//           |                         | overflow_drop, cancel_seen, fill_count
// config    | cfg_valid & cfg_ready   | cfg_index, cfg_data
//
// while results drain, one item per cycle is sustained and the back end
// executes one command a cycle, with one access to the byte store (one write
// or one registered read); inputs pass the command queue, s2 and result queue
// rst is synchronous and clears pointers, counts, queues and decode state;
// the byte store itself is not cleared and needs no clearing pass
// a stalled result side backs up the result queue, then the back end, then
// the command queue, after which full rises; the front never waits on the back

module escape_decode_rx_fifo_with_abort #(
  parameter int unsigned FIFO_DEPTH = edrx_pkg::FIFO_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] rx_byte,
  input  wire logic       long_transfer,
  // result channel
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      read_byte,
  output logic            read_valid,
  output logic            byte_stored,
  output logic            overflow_drop,
  output logic            cancel_seen,
  output logic [8:0]      fill_count,
  // configuration channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  import edrx_pkg::*;

  localparam int unsigned QC_W = $clog2(QUEUE_DEPTH+1);

  logic            in_fire;
  cmd_t            cmd_in;
  cmd_t            cmd_head;
  logic            cmd_empty;
  logic            cmd_pop;
  logic [QC_W-1:0] cmd_count;

  logic            res_push;
  res_t            res_in;
  res_t            res_head;
  logic            res_full;
  logic [QC_W-1:0] res_count;

  // config registers take a write in any cycle
  assign cfg_ready = 1'b1;
  assign in_fire   = push && !full;

  // front: abort matching, unstuffing and classification into a command
  edrx_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_fire       (in_fire),
    .operation     (operation),
    .rx_byte       (rx_byte),
    .long_transfer (long_transfer),
    .cmd           (cmd_in)
  );

  // command queue between front and back; its full flag is the input's full
  edrx_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (cmd_in),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty),
    .count     (cmd_count)
  );

  // back: byte store, pointers and fill count
  edrx_back #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .RQ_DEPTH   (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // result queue; space is reserved by the back end, so pushes never see full
  edrx_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_head),
    .empty     (empty),
    .count     (res_count)
  );

  assign read_byte     = res_head.read_byte;
  assign read_valid    = res_head.read_valid;
  assign byte_stored   = res_head.byte_stored;
  assign overflow_drop = res_head.overflow_drop;
  assign cancel_seen   = res_head.cancel_seen;
  assign fill_count    = res_head.fill_count;

  // the credit check must keep the result queue from ever overrunning
  a_res_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overrun");

  // at most one outcome flag per result
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    !empty |-> $onehot0({read_valid, byte_stored, overflow_drop, cancel_seen}))
    else $error("more than one outcome flag set");

  // an abort always leaves the store empty
  a_cancel_flushes: assert property (@(posedge clk) disable iff (rst)
    (!empty && cancel_seen) |-> (fill_count == 9'd0))
    else $error("abort did not flush the store");

  // the command queue drains whenever the result queue is empty
  a_cmd_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd_count != '0 && res_count == '0) |-> cmd_pop)
    else $error("back end stalled with an empty result queue");

endmodule

`default_nettype wire

>>> sv/edrx_queue.sv
`default_nettype none

module edrx_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = edrx_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             push_data,
  output logic                              full,
  input  wire logic                         pop,
  output logic [WIDTH-1:0]                  pop_data,
  output logic                              empty,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/edrx_front.sv
`default_nettype none

module edrx_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_fire,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        long_transfer,
  output edrx_pkg::cmd_t   cmd
);

  import edrx_pkg::*;

  logic [7:0] header_byte;
  logic [7:0] escape_byte;
  logic [7:0] escape_offset;
  logic [7:0] cancel_opcode;
  logic [2:0] match_idx;
  logic [2:0] match_idx_next;
  logic       escape_pending;
  logic       escape_pending_next;

  logic [2:0] start_idx;
  logic [2:0] adv_idx;
  logic       seq_hit;
  logic       abort_done;
  logic       esc_cleared;

  // abort matcher: FE always restarts at the first position
  always_comb begin
    start_idx = (rx_byte == ABORT_BYTE0) ? 3'd0 : match_idx;
    if (start_idx >= ABORT_LEN) begin
      start_idx = 3'd0;
    end
    seq_hit    = (rx_byte == abort_byte(start_idx, cancel_opcode));
    adv_idx    = start_idx + 3'd1;
    abort_done = seq_hit && (adv_idx == ABORT_LEN);
  end

  always_comb begin
    match_idx_next      = match_idx;
    escape_pending_next = escape_pending;
    esc_cleared         = escape_pending && (rx_byte != header_byte);
    cmd.kind            = CMD_NONE;
    cmd.data            = rx_byte;
    unique case (operation)
      OP_RECEIVE: begin
        match_idx_next = (seq_hit && !abort_done) ? adv_idx : 3'd0;
        if (abort_done) begin
          cmd.kind = CMD_ABORT;
        end else if (rx_byte == escape_byte && !long_transfer) begin
          escape_pending_next = 1'b1;
        end else begin
          escape_pending_next = 1'b0;
          cmd.kind            = CMD_PUSH;
          cmd.data            = esc_cleared ? rx_byte + escape_offset : rx_byte;
        end
      end
      OP_READ:  cmd.kind = CMD_READ;
      OP_FLUSH: cmd.kind = CMD_FLUSH;
      default:  cmd.kind = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte    <= HEADER_RESET;
      escape_byte    <= ESCAPE_RESET;
      escape_offset  <= ESCAPE_OFFSET_RESET;
      cancel_opcode  <= CANCEL_OPCODE_RESET;
      match_idx      <= 3'd0;
      escape_pending <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_HEADER:        header_byte   <= cfg_data;
          REG_ESCAPE:        escape_byte   <= cfg_data;
          REG_ESCAPE_OFFSET: escape_offset <= cfg_data;
          REG_CANCEL_OPCODE: cancel_opcode <= cfg_data;
        endcase
      end
      if (in_fire) begin
        match_idx      <= match_idx_next;
        escape_pending <= escape_pending_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/edrx_back.sv
`default_nettype none

module edrx_back #(
  parameter int unsigned FIFO_DEPTH = edrx_pkg::FIFO_DEPTH_DEFAULT,
  parameter int unsigned RQ_DEPTH   = edrx_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_empty,
  input  wire edrx_pkg::cmd_t                cmd_head,
  output logic                               cmd_pop,
  input  wire logic [$clog2(RQ_DEPTH+1)-1:0] res_count,
  output logic                               res_push,
  output edrx_pkg::res_t                     res_data
);

  import edrx_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned OCC_W = $clog2(FIFO_DEPTH+1);
  localparam int unsigned RC_W  = $clog2(RQ_DEPTH+1);

  logic [7:0]       store [FIFO_DEPTH];
  logic [7:0]       store_q;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;
  logic [OCC_W+FILL_W-1:0] occ_wide;

  logic       fire;
  logic [RC_W:0] slots_used;
  logic       do_write;
  logic       do_read;
  logic       stored_next;
  logic       drop_next;
  logic       cancel_next;

  logic       s2_valid;
  res_t       s2;

  // a slot in the result queue is reserved before a command executes
  assign slots_used = {1'b0, res_count} + {{RC_W{1'b0}}, s2_valid};
  assign fire       = !cmd_empty && (slots_used < (RC_W+1)'(RQ_DEPTH));
  assign cmd_pop    = fire;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    occ_next    = occ;
    do_write    = 1'b0;
    do_read     = 1'b0;
    stored_next = 1'b0;
    drop_next   = 1'b0;
    cancel_next = 1'b0;
    unique case (cmd_head.kind)
      CMD_PUSH: begin
        if (occ == OCC_W'(FIFO_DEPTH)) begin
          drop_next = 1'b1;
        end else begin
          do_write    = 1'b1;
          stored_next = 1'b1;
          wr_ptr_next = (wr_ptr == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
          occ_next    = occ + 1'b1;
        end
      end
      CMD_READ: begin
        if (occ != '0) begin
          do_read     = 1'b1;
          rd_ptr_next = (rd_ptr == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
          occ_next    = occ - 1'b1;
        end
      end
      CMD_FLUSH: begin
        wr_ptr_next = '0;
        rd_ptr_next = '0;
        occ_next    = '0;
      end
      CMD_ABORT: begin
        wr_ptr_next = '0;
        rd_ptr_next = '0;
        occ_next    = '0;
        cancel_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // fill count reported on 9 bits, wrapped for deeper stores
  assign occ_wide = {{FILL_W{1'b0}}, occ_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      occ      <= '0;
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= fire;
      if (fire) begin
        wr_ptr <= wr_ptr_next;
        rd_ptr <= rd_ptr_next;
        occ    <= occ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2.read_byte     <= 8'd0;
    s2.read_valid    <= fire && do_read;
    s2.byte_stored   <= stored_next;
    s2.overflow_drop <= drop_next;
    s2.cancel_seen   <= cancel_next;
    s2.fill_count    <= occ_wide[FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (fire && do_write) begin
      store[wr_ptr] <= cmd_head.data;
    end
    if (fire && do_read) begin
      store_q <= store[rd_ptr];
    end
  end

  always_comb begin
    res_push           = s2_valid;
    res_data           = s2;
    res_data.read_byte = s2.read_valid ? store_q : 8'd0;
  end

endmodule

`default_nettype wire

>>> tb/rx_status_checker.sv
module rx_status_checker #(
  parameter int unsigned FIFO_DEPTH = edrx_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] operation,
  input  logic [7:0] rx_byte,
  input  logic       long_transfer,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] read_byte,
  input  logic       read_valid,
  input  logic       byte_stored,
  input  logic       overflow_drop,
  input  logic       cancel_seen,
  input  logic [8:0] fill_count,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         outstanding
);

  import edrx_pkg::*;

  logic [7:0]  header_val;
  logic [7:0]  escape_val;
  logic [7:0]  offset_val;
  logic [7:0]  cancel_val;

  logic [7:0]  ring [FIFO_DEPTH];
  int unsigned ring_head;
  int unsigned ring_tail;
  int unsigned ring_count;
  int unsigned abort_pos;
  logic        escape_armed;

  res_t        status_due [$];
  res_t        oldest;

  function automatic res_t decode_operation(input logic [1:0] op, input logic [7:0] b,
                                            input logic lx);
    res_t       r;
    logic [7:0] want;
    logic [7:0] v;
    logic       aborted;
    r = '0;
    case (op)
      OP_RECEIVE: begin
        // header of the abort sequence always restarts the match
        if (b == ABORT_BYTE0) abort_pos = 0;
        case (abort_pos)
          0:       want = ABORT_BYTE0;
          1:       want = ABORT_BYTE1;
          2:       want = cancel_val;
          3:       want = ABORT_BYTE3;
          default: want = ABORT_BYTE4;
        endcase
        aborted = 1'b0;
        if (b == want) begin
          abort_pos++;
          if (abort_pos == ABORT_LEN) begin
            abort_pos = 0;
            aborted = 1'b1;
          end
        end else begin
          abort_pos = 0;
        end
        if (aborted) begin
          // escape flag survives the abort
          ring_head     = 0;
          ring_tail     = 0;
          ring_count    = 0;
          r.cancel_seen = 1'b1;
        end else begin
          if (b == header_val) escape_armed = 1'b0;
          if (b == escape_val && !lx) begin
            escape_armed = 1'b1;
          end else begin
            v = escape_armed ? b + offset_val : b;
            escape_armed = 1'b0;
            if (ring_count >= FIFO_DEPTH) begin
              r.overflow_drop = 1'b1;
            end else begin
              ring[ring_tail] = v;
              ring_tail       = (ring_tail + 1) % FIFO_DEPTH;
              ring_count++;
              r.byte_stored   = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        if (ring_count > 0) begin
          r.read_byte  = ring[ring_head];
          r.read_valid = 1'b1;
          ring_head    = (ring_head + 1) % FIFO_DEPTH;
          ring_count--;
        end
      end
      OP_FLUSH: begin
        ring_head  = 0;
        ring_tail  = 0;
        ring_count = 0;
      end
      default: begin
      end
    endcase
    r.fill_count = FILL_W'(ring_count);
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      header_val   = HEADER_RESET;
      escape_val   = ESCAPE_RESET;
      offset_val   = ESCAPE_OFFSET_RESET;
      cancel_val   = CANCEL_OPCODE_RESET;
      ring_head    = 0;
      ring_tail    = 0;
      ring_count   = 0;
      abort_pos    = 0;
      escape_armed = 1'b0;
      fail_count   = 0;
      status_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEADER:        header_val = cfg_data;
          REG_ESCAPE:        escape_val = cfg_data;
          REG_ESCAPE_OFFSET: offset_val = cfg_data;
          REG_CANCEL_OPCODE: cancel_val = cfg_data;
          default: begin
          end
        endcase
      end
      if (pop && !empty) begin
        if (status_due.size() == 0) begin
          $display("%0t: result transfer with none expected, expected nothing, actual fill 0x%0h",
                   $time, fill_count);
          fail_count++;
        end else begin
          oldest = status_due.pop_front();
          check_field("read_byte", oldest.read_byte, read_byte);
          check_field("read_valid", oldest.read_valid, read_valid);
          check_field("byte_stored", oldest.byte_stored, byte_stored);
          check_field("overflow_drop", oldest.overflow_drop, overflow_drop);
          check_field("cancel_seen", oldest.cancel_seen, cancel_seen);
          check_field("fill_count", oldest.fill_count, fill_count);
        end
      end
      if (push && !full) begin
        status_due.push_back(decode_operation(operation, rx_byte, long_transfer));
      end
    end
    outstanding = status_due.size();
  end

endmodule

>>> tb/testbench.sv
module testbench;
  import edrx_pkg::*;

  // operation code the block must ignore
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  // length of the long result-side hold-off
  localparam int         STALL_CYCLES = 200;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       push          = 1'b0;
  logic [1:0] operation     = OP_RECEIVE;
  logic [7:0] rx_byte       = 8'h00;
  logic       long_transfer = 1'b0;
  logic       pop           = 1'b0;
  logic       cfg_valid     = 1'b0;
  logic [1:0] cfg_index     = REG_HEADER;
  logic [7:0] cfg_data      = 8'h00;

  logic       full;
  logic       empty;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       byte_stored;
  logic       overflow_drop;
  logic       cancel_seen;
  logic [8:0] fill_count;
  logic       cfg_ready;

  int         fail_count;
  int         outstanding;

  // traffic shaping shared by sender and receiver
  logic       steady       = 1'b0;
  logic       hold_results = 1'b0;
  event       start_stall;
  int         ops_sent     = 0;

  // register values currently loaded, used to build meaningful byte streams
  logic [7:0] cur_header = HEADER_RESET;
  logic [7:0] cur_escape = ESCAPE_RESET;
  logic [7:0] cur_cancel = CANCEL_OPCODE_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  escape_decode_rx_fifo_with_abort dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .rx_byte      (rx_byte),
    .long_transfer(long_transfer),
    .empty        (empty),
    .pop          (pop),
    .read_byte    (read_byte),
    .read_valid   (read_valid),
    .byte_stored  (byte_stored),
    .overflow_drop(overflow_drop),
    .cancel_seen  (cancel_seen),
    .fill_count   (fill_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rx_status_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .rx_byte      (rx_byte),
    .long_transfer(long_transfer),
    .empty        (empty),
    .pop          (pop),
    .read_byte    (read_byte),
    .read_valid   (read_valid),
    .byte_stored  (byte_stored),
    .overflow_drop(overflow_drop),
    .cancel_seen  (cancel_seen),
    .fill_count   (fill_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // result side: random pop gaps, none while steady, nothing at all during a hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= !hold_results && (steady || $urandom_range(99) >= 9);
    end
  end

  // long hold-off on the result side, counted here so the sender keeps offering
  initial begin : result_hold
    forever begin
      @(start_stall);
      hold_results <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clk);
      hold_results <= 1'b0;
    end
  end

  // one operation transfer, with an occasional one-cycle gap in front of it
  task automatic send_op(input logic [1:0] op, input logic [7:0] b, input logic lx);
    if (!steady && $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    operation     <= op;
    rx_byte       <= b;
    long_transfer <= lx;
    do @(posedge clk); while (full);
    ops_sent++;
  endtask

  // all four registers back to back, valid held high between transfers
  task automatic load_registers(input logic [7:0] hdr, input logic [7:0] esc,
                                input logic [7:0] ofs, input logic [7:0] cnc);
    logic [1:0] idx  [4];
    logic [7:0] vals [4];
    idx  = '{REG_HEADER, REG_ESCAPE, REG_ESCAPE_OFFSET, REG_CANCEL_OPCODE};
    vals = '{hdr, esc, ofs, cnc};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    cur_header  = hdr;
    cur_escape  = esc;
    cur_cancel  = cnc;
  endtask

  // stop offering and let every expected result come back
  task automatic wait_quiet();
    push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // byte values biased toward the ones the decoder treats specially
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return cur_header;
      1:       return cur_escape;
      2:       return ABORT_BYTE0;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // random episodes: abort sequences (some broken), escape pairs, read bursts,
  // flushes, ignored codes and plain receive bursts
  task automatic random_traffic(input int count);
    int         first;
    int         kind;
    logic       lx;
    logic [7:0] seq [5];
    first = ops_sent;
    while (ops_sent - first < count) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        seq = '{ABORT_BYTE0, ABORT_BYTE1, cur_cancel, ABORT_BYTE3, ABORT_BYTE4};
        if ($urandom_range(3) == 0) seq[$urandom_range(4)] = 8'($urandom_range(255));
        // an escape armed just before the abort must survive it
        if ($urandom_range(3) == 0) send_op(OP_RECEIVE, cur_escape, 1'b0);
        lx = 1'($urandom_range(1));
        foreach (seq[i]) send_op(OP_RECEIVE, seq[i], lx);
      end else if (kind < 45) begin
        lx = ($urandom_range(4) == 0);
        send_op(OP_RECEIVE, cur_escape, lx);
        if ($urandom_range(2) == 0) send_op(OP_RECEIVE, cur_header, 1'b0);
        send_op(OP_RECEIVE, pick_byte(), 1'($urandom_range(1)));
      end else if (kind < 68) begin
        repeat ($urandom_range(8, 1)) send_op(OP_READ, pick_byte(), 1'($urandom_range(1)));
      end else if (kind < 72) begin
        send_op(OP_FLUSH, pick_byte(), 1'($urandom_range(1)));
      end else if (kind < 74) begin
        send_op(OP_UNUSED, pick_byte(), 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(12, 1)) begin
          send_op(OP_RECEIVE, pick_byte(), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset register values
    send_op(OP_READ,    8'h00, 1'b0);  // read from empty
    send_op(OP_UNUSED,  8'hFF, 1'b1);  // ignored code
    send_op(OP_RECEIVE, 8'h00, 1'b0);
    send_op(OP_RECEIVE, 8'hFF, 1'b0);
    send_op(OP_RECEIVE, 8'hFD, 1'b0);  // escape armed
    send_op(OP_RECEIVE, 8'hFF, 1'b0);  // offset wraps to zero
    send_op(OP_RECEIVE, 8'hFD, 1'b1);  // escape stored as is in a long transfer
    send_op(OP_RECEIVE, 8'hFD, 1'b0);  // escape armed
    send_op(OP_RECEIVE, 8'hFE, 1'b0);  // header clears it, starts abort match
    send_op(OP_RECEIVE, 8'h03, 1'b0);
    send_op(OP_RECEIVE, 8'h00, 1'b0);
    send_op(OP_RECEIVE, 8'h99, 1'b0);
    send_op(OP_RECEIVE, 8'h50, 1'b0);  // abort completes, store flushed
    send_op(OP_RECEIVE, 8'hFE, 1'b0);
    send_op(OP_RECEIVE, 8'h03, 1'b0);
    send_op(OP_RECEIVE, 8'hFE, 1'b0);  // restart of the match mid-sequence
    send_op(OP_RECEIVE, 8'h03, 1'b0);
    send_op(OP_RECEIVE, 8'h00, 1'b0);
    send_op(OP_RECEIVE, 8'h99, 1'b0);
    send_op(OP_RECEIVE, 8'h50, 1'b0);  // abort again
    send_op(OP_READ,    8'hFF, 1'b1);  // empty after abort
    send_op(OP_RECEIVE, 8'h7F, 1'b1);
    send_op(OP_READ,    8'h00, 1'b0);
    send_op(OP_RECEIVE, 8'h80, 1'b0);
    send_op(OP_FLUSH,   8'hFF, 1'b1);
    send_op(OP_READ,    8'h00, 1'b0);
    wait_quiet();

    // register settings, extremes among them, each with a random phase
    load_registers(HEADER_RESET, ESCAPE_RESET, ESCAPE_OFFSET_RESET, CANCEL_OPCODE_RESET);
    random_traffic(250);
    wait_quiet();

    // header equal to escape, with no gaps on either side
    load_registers(8'h00, 8'h00, 8'hFF, 8'hFF);
    steady <= 1'b1;
    random_traffic(250);
    wait_quiet();
    steady <= 1'b0;

    // escape byte equal to the abort header
    load_registers(8'h7E, ABORT_BYTE0, 8'h20, ABORT_BYTE1);
    random_traffic(250);
    wait_quiet();

    // cancel opcode equal to the abort header, so no abort can complete
    load_registers(8'hFF, 8'hFF, 8'h00, ABORT_BYTE0);
    random_traffic(250);
    wait_quiet();

    load_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    random_traffic(250);

    // fill past the top while results are held off, then drain past empty
    send_op(OP_FLUSH, 8'h00, 1'b0);
    -> start_stall;
    repeat (262) send_op(OP_RECEIVE, 8'($urandom_range(253)), 1'b1);
    repeat (262) send_op(OP_READ, pick_byte(), 1'($urandom_range(1)));

    wait_quiet();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #500_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
